@@ src/kvt_pkg.sv @@
package kvt_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 64;
  localparam int MODE_W      = 3;
  localparam int RANK_W      = 4;
  localparam int CNT_FIELD_W = 5;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);

  localparam int IN_BITS     = MODE_W + KEY_W + VAL_W + RANK_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 2 + KEY_W + VAL_W + CNT_FIELD_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  // Broadcast to every cell: shift right to open a gap, shift left to close one, or
  // overwrite the value of the matching cell.
  typedef struct packed {
    logic ins;
    logic ers;
    logic upd;
  } cell_ctrl_t;

  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] hit_key;
    logic [VAL_W-1:0] hit_value;
    logic [KEY_W-1:0] rank_key;
    logic [VAL_W-1:0] rank_value;
  } chain_stat_t;

endpackage

@@ src/kvt_cell.sv @@
module kvt_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  kvt_pkg::cell_ctrl_t      ctrl,
  input  logic [kvt_pkg::KEY_W-1:0] req_key,
  input  logic [kvt_pkg::VAL_W-1:0] req_value,
  input  kvt_pkg::entry_t          prev_ent,
  input  logic                     prev_lt,
  input  kvt_pkg::entry_t          next_ent,
  output kvt_pkg::entry_t          ent,
  output logic                     lt,
  output logic                     eq
);

  kvt_pkg::entry_t ent_r;
  kvt_pkg::entry_t ent_nxt;

  assign ent = ent_r;
  assign lt  = ent_r.valid && (ent_r.key < req_key);
  assign eq  = ent_r.valid && (ent_r.key == req_key);

  // Valid cells sit at the front of the row in ascending key order, so a cell whose
  // key is below the request key never moves.
  always_comb begin
    ent_nxt = ent_r;
    priority if (ctrl.ins) begin
      if (!lt) begin
        if (prev_lt) begin
          ent_nxt.valid = 1'b1;
          ent_nxt.key   = req_key;
          ent_nxt.value = req_value;
        end else begin
          ent_nxt = prev_ent;
        end
      end
    end else if (ctrl.ers) begin
      if (!lt) begin
        ent_nxt = next_ent;
      end
    end else if (ctrl.upd && eq) begin
      ent_nxt.value = req_value;
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

@@ src/kvt_chain.sv @@
module kvt_chain (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kvt_pkg::cell_ctrl_t       ctrl,
  input  logic [kvt_pkg::KEY_W-1:0] req_key,
  input  logic [kvt_pkg::VAL_W-1:0] req_value,
  input  logic [kvt_pkg::IDX_W-1:0] rank_idx,
  output kvt_pkg::chain_stat_t      stat
);

  kvt_pkg::entry_t ents   [kvt_pkg::NUM_ENTRIES];
  kvt_pkg::entry_t prev_e [kvt_pkg::NUM_ENTRIES];
  kvt_pkg::entry_t next_e [kvt_pkg::NUM_ENTRIES];
  logic            prev_l [kvt_pkg::NUM_ENTRIES];
  logic            lts    [kvt_pkg::NUM_ENTRIES];
  logic            eqs    [kvt_pkg::NUM_ENTRIES];

  for (genvar g = 0; g < kvt_pkg::NUM_ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_e[g] = '0;
      assign prev_l[g] = 1'b1;
    end else begin : g_body
      assign prev_e[g] = ents[g-1];
      assign prev_l[g] = lts[g-1];
    end

    if (g == kvt_pkg::NUM_ENTRIES - 1) begin : g_tail
      assign next_e[g] = '0;
    end else begin : g_inner
      assign next_e[g] = ents[g+1];
    end

    kvt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .req_key   (req_key),
      .req_value (req_value),
      .prev_ent  (prev_e[g]),
      .prev_lt   (prev_l[g]),
      .next_ent  (next_e[g]),
      .ent       (ents[g]),
      .lt        (lts[g]),
      .eq        (eqs[g])
    );
  end

  // Keys are unique, so at most one cell matches and the OR acts as a one-hot select.
  always_comb begin
    stat.hit       = 1'b0;
    stat.hit_key   = '0;
    stat.hit_value = '0;
    for (int i = 0; i < kvt_pkg::NUM_ENTRIES; i++) begin
      if (eqs[i]) begin
        stat.hit       = 1'b1;
        stat.hit_key   = stat.hit_key | ents[i].key;
        stat.hit_value = stat.hit_value | ents[i].value;
      end
    end
    stat.rank_key   = ents[rank_idx].key;
    stat.rank_value = ents[rank_idx].value;
  end

endmodule

@@ src/key_value_table_unit.sv @@
// Key/value table of up to 16 unique pairs (32-bit key, 64-bit value) held as a row of
// cells kept in ascending key order. Each request transaction on the in_ side carries an
// operation (insert, update, insert-or-update, erase, lookup, get by rank) and yields
// exactly one result transaction on the out_ side with ok, full_flag, the key and value
// found and the entry count after the operation. A request is first registered; then,
// once the result register is free, every cell compares its key with the request key
// and shifts, reloads or keeps its contents while the result register is loaded. One
// request is in hand at a time; a further request is accepted while a result still
// waits on out_tready, and is held until the result register is free. The table is
// empty after reset.
module key_value_table_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // mode[2:0], req_key[34:3], req_value[98:35], rank_index[102:99], zero pad above
  input  logic [kvt_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // ok[0], full_flag[1], found_key[33:2], found_value[97:34], entry_count[102:98],
  // zero pad above
  output logic [kvt_pkg::OUT_TDATA_W-1:0] out_tdata
);

  typedef enum logic [kvt_pkg::MODE_W-1:0] {
    OP_INSERT = 3'd0,
    OP_UPDATE = 3'd1,
    OP_UPSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_LOOKUP = 3'd4,
    OP_RANK   = 3'd5
  } op_t;

  localparam int KEY_LO  = kvt_pkg::MODE_W;
  localparam int VAL_LO  = KEY_LO + kvt_pkg::KEY_W;
  localparam int RANK_LO = VAL_LO + kvt_pkg::VAL_W;

  logic                          req_vld_r;
  logic [kvt_pkg::MODE_W-1:0]    mode_r;
  logic [kvt_pkg::KEY_W-1:0]     key_r;
  logic [kvt_pkg::VAL_W-1:0]     val_r;
  logic [kvt_pkg::RANK_W-1:0]    rank_r;
  logic [kvt_pkg::CNT_W-1:0]     count_r;
  logic [kvt_pkg::CNT_W-1:0]     count_nxt;

  logic                          out_vld_r;
  logic                          ok_r;
  logic                          full_r;
  logic [kvt_pkg::KEY_W-1:0]     fkey_r;
  logic [kvt_pkg::VAL_W-1:0]     fval_r;
  logic [kvt_pkg::CNT_W-1:0]     ocount_r;

  logic                          ok_nxt;
  logic                          full_nxt;
  logic [kvt_pkg::KEY_W-1:0]     fkey_nxt;
  logic [kvt_pkg::VAL_W-1:0]     fval_nxt;

  logic                          in_acc;
  logic                          exec;
  logic                          tbl_full;
  logic                          rank_ok;
  kvt_pkg::cell_ctrl_t           ctrl;
  kvt_pkg::cell_ctrl_t           op_ctrl;
  kvt_pkg::chain_stat_t          stat;

  assign in_tready = !req_vld_r;
  assign in_acc    = in_tvalid && in_tready;
  assign exec      = req_vld_r && (!out_vld_r || out_tready);
  assign tbl_full  = (32'(count_r) == kvt_pkg::NUM_ENTRIES);
  assign rank_ok   = (32'(rank_r) < 32'(count_r));
  assign ctrl      = exec ? op_ctrl : '0;

  kvt_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .req_key   (key_r),
    .req_value (val_r),
    .rank_idx  (kvt_pkg::IDX_W'(rank_r)),
    .stat      (stat)
  );

  always_comb begin
    op_ctrl   = '0;
    ok_nxt    = 1'b0;
    full_nxt  = 1'b0;
    fkey_nxt  = '0;
    fval_nxt  = '0;
    count_nxt = count_r;
    unique case (mode_r)
      OP_INSERT, OP_UPSERT: begin
        if (stat.hit) begin
          if (mode_r == OP_UPSERT) begin
            op_ctrl.upd = 1'b1;
            ok_nxt      = 1'b1;
          end
        end else if (tbl_full) begin
          full_nxt = 1'b1;
        end else begin
          op_ctrl.ins = 1'b1;
          ok_nxt      = 1'b1;
          count_nxt   = count_r + 1'b1;
        end
      end
      OP_UPDATE: begin
        op_ctrl.upd = stat.hit;
        ok_nxt      = stat.hit;
      end
      OP_ERASE: begin
        if (stat.hit) begin
          op_ctrl.ers = 1'b1;
          ok_nxt      = 1'b1;
          count_nxt   = count_r - 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (stat.hit) begin
          ok_nxt   = 1'b1;
          fkey_nxt = stat.hit_key;
          fval_nxt = stat.hit_value;
        end
      end
      OP_RANK: begin
        if (rank_ok) begin
          ok_nxt   = 1'b1;
          fkey_nxt = stat.rank_key;
          fval_nxt = stat.rank_value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      count_r   <= '0;
    end else begin
      if (in_acc) begin
        req_vld_r <= 1'b1;
      end else if (exec) begin
        req_vld_r <= 1'b0;
      end

      if (exec) begin
        out_vld_r <= 1'b1;
        count_r   <= count_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_tdata[KEY_LO-1:0];
      key_r  <= in_tdata[VAL_LO-1:KEY_LO];
      val_r  <= in_tdata[RANK_LO-1:VAL_LO];
      rank_r <= in_tdata[RANK_LO+kvt_pkg::RANK_W-1:RANK_LO];
    end
    if (exec) begin
      ok_r     <= ok_nxt;
      full_r   <= full_nxt;
      fkey_r   <= fkey_nxt;
      fval_r   <= fval_nxt;
      ocount_r <= count_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {
    (kvt_pkg::OUT_TDATA_W - kvt_pkg::OUT_BITS)'(0),
    kvt_pkg::CNT_FIELD_W'(ocount_r),
    fval_r,
    fkey_r,
    full_r,
    ok_r
  };

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= kvt_pkg::NUM_ENTRIES)
    else $error("entry count exceeds table size");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_tvalid)
    else $error("executed request produced no result");

  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (req_vld_r && !in_tready))
    else $error("accepted request not held");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(ok_r && full_r))
    else $error("ok and full_flag both set");
`endif

endmodule

@@ test/key_value_table_checker.sv @@
package kvt_tb_pkg;

  import kvt_pkg::*;

  typedef enum logic [MODE_W-1:0] {
    OP_INSERT,
    OP_UPDATE,
    OP_UPSERT,
    OP_ERASE,
    OP_LOOKUP,
    OP_RANK,
    OP_RSVD6,
    OP_RSVD7
  } op_e;

  // Laid out as on in_tdata: mode in the lowest bits, zero pad at the top.
  typedef struct packed {
    logic [IN_TDATA_W-IN_BITS-1:0] pad;
    logic [RANK_W-1:0]             rank;
    logic [VAL_W-1:0]              value;
    logic [KEY_W-1:0]              key;
    op_e                           mode;
  } kvt_request_t;

  // Laid out as on out_tdata: ok in bit 0, zero pad at the top.
  typedef struct packed {
    logic [OUT_TDATA_W-OUT_BITS-1:0] pad;
    logic [CNT_FIELD_W-1:0]          count;
    logic [VAL_W-1:0]                value;
    logic [KEY_W-1:0]                key;
    logic                            full;
    logic                            ok;
  } kvt_result_t;

endpackage

module key_value_table_checker
  import kvt_pkg::*;
  import kvt_tb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     mismatch_count,
  output int                     results_owed
);

  logic             slot_used [NUM_ENTRIES];
  logic [KEY_W-1:0] slot_key  [NUM_ENTRIES];
  logic [VAL_W-1:0] slot_val  [NUM_ENTRIES];

  kvt_result_t owed_results [$];
  int          error_tally = 0;

  initial begin
    mismatch_count = 0;
    results_owed   = 0;
  end

  // Applies one request to the shadow table and returns the result it must produce.
  function automatic kvt_result_t apply_request(input kvt_request_t rq);
    kvt_result_t r;
    int          hit_idx;
    int          free_idx;
    int          below;
    int          used;
    r        = '0;
    hit_idx  = -1;
    free_idx = -1;
    used     = 0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (slot_used[i] && slot_key[i] == rq.key && hit_idx < 0) hit_idx = i;
      if (!slot_used[i] && free_idx < 0) free_idx = i;
    end
    case (rq.mode)
      OP_INSERT, OP_UPSERT: begin
        if (hit_idx >= 0) begin
          if (rq.mode == OP_UPSERT) begin
            slot_val[hit_idx] = rq.value;
            r.ok = 1'b1;
          end
        end else if (free_idx < 0) begin
          r.full = 1'b1;
        end else begin
          slot_used[free_idx] = 1'b1;
          slot_key[free_idx]  = rq.key;
          slot_val[free_idx]  = rq.value;
          r.ok = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (hit_idx >= 0) begin
          slot_val[hit_idx] = rq.value;
          r.ok = 1'b1;
        end
      end
      OP_ERASE: begin
        if (hit_idx >= 0) begin
          slot_used[hit_idx] = 1'b0;
          r.ok = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (hit_idx >= 0) begin
          r.ok    = 1'b1;
          r.key   = slot_key[hit_idx];
          r.value = slot_val[hit_idx];
        end
      end
      OP_RANK: begin
        // Keys are unique, so at most one entry has a given number of smaller keys.
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (slot_used[i] && !r.ok) begin
            below = 0;
            for (int j = 0; j < NUM_ENTRIES; j++)
              if (slot_used[j] && slot_key[j] < slot_key[i]) below++;
            if (below == int'(rq.rank)) begin
              r.ok    = 1'b1;
              r.key   = slot_key[i];
              r.value = slot_val[i];
            end
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (slot_used[i]) used++;
    r.count = CNT_FIELD_W'(used);
    return r;
  endfunction

  always @(posedge clk) begin
    kvt_result_t seen;
    kvt_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_ENTRIES; i++) slot_used[i] = 1'b0;
      owed_results.delete();
    end else begin
      // A result always leaves after its request has been registered, so take it first.
      if (out_tvalid && out_tready) begin
        seen = kvt_result_t'(out_tdata);
        if (owed_results.size() == 0) begin
          error_tally++;
          if (error_tally <= 10)
            $display("unexpected result transaction: ok %0b full %0b key %h value %h count %0d",
                     seen.ok, seen.full, seen.key, seen.value, seen.count);
        end else begin
          want = owed_results.pop_front();
          if (seen.ok !== want.ok || seen.full !== want.full || seen.key !== want.key ||
              seen.value !== want.value || seen.count !== want.count) begin
            error_tally++;
            if (error_tally <= 10) begin
              $display("result mismatch (expected / actual):");
              $display("  ok %0b / %0b  full %0b / %0b  count %0d / %0d",
                       want.ok, seen.ok, want.full, seen.full, want.count, seen.count);
              $display("  key %h / %h  value %h / %h",
                       want.key, seen.key, want.value, seen.value);
            end
          end
        end
      end
      if (in_tvalid && in_tready)
        owed_results.push_back(apply_request(kvt_request_t'(in_tdata)));
    end
    mismatch_count <= error_tally;
    results_owed   <= owed_results.size();
  end

endmodule

@@ test/key_value_table_unit_test.sv @@
module key_value_table_unit_test;

  import kvt_pkg::*;
  import kvt_tb_pkg::*;

  localparam int RANDOM_REQUESTS = 600;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int KEY_POOL_SIZE   = 24;
  localparam int LONG_HOLD       = 80;
  localparam int SETTLE_CYCLES   = 20;

  typedef enum {PH_FILL, PH_MIX, PH_DRAIN} phase_e;
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_style_e;

  // Operation weights per phase, in percent, indexed by operation code.
  localparam int OP_WEIGHT [3][8] = '{
    '{40,  5, 25,  5,  8, 12, 3, 2},
    '{15, 12, 15, 15, 15, 22, 3, 3},
    '{ 8,  5,  5, 45, 12, 20, 3, 2}
  };

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int               mismatches;
  int               results_owed;
  int               cycles         = 0;
  int               burst_left     = 0;
  logic             long_stall_tog = 1'b0;
  logic             hold_seen      = 1'b0;
  int               hold_left      = 0;
  rx_style_e        rx_style       = RX_OPEN;
  int               rx_left        = 0;
  logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

  key_value_table_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  key_value_table_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatch_count(mismatches),
    .results_owed  (results_owed)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: a changing stall pattern, plus a long hold each time the toggle flips.
  always @(posedge clk) begin
    if (long_stall_tog != hold_seen) begin
      hold_seen  <= long_stall_tog;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_style <= rx_style_e'($urandom_range(0, 3));
        rx_left  <= $urandom_range(5, 60);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_style)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 4) == 0);
        default:   out_tready <= (cycles % 3 == 0);
      endcase
    end
  end

  function automatic kvt_request_t make_request(input op_e op, input logic [KEY_W-1:0] key,
                                                input logic [VAL_W-1:0] value,
                                                input logic [RANK_W-1:0] rank);
    kvt_request_t rq;
    rq       = '0;
    rq.mode  = op;
    rq.key   = key;
    rq.value = value;
    rq.rank  = rank;
    return rq;
  endfunction

  function automatic op_e pick_op(input phase_e phase);
    int roll;
    int acc;
    roll = $urandom_range(0, 99);
    acc  = 0;
    for (int m = 0; m < 8; m++) begin
      acc += OP_WEIGHT[int'(phase)][m];
      if (roll < acc) return op_e'(m);
    end
    return OP_RSVD7;
  endfunction

  // Mostly keys from a pool larger than the table, so hits, misses and a full table all occur.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 7) == 0) return KEY_W'($urandom);
    return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    return {$urandom, $urandom};
  endfunction

  // Presents one request and returns at the edge where the transaction completes.
  task automatic offer(input kvt_request_t rq);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= rq;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_until_drained();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  initial begin
    phase_e phase;
    for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: rank and update both miss.
    offer(make_request(OP_RANK, '0, '0, '0));
    offer(make_request(OP_UPDATE, KEY_W'(1), VAL_W'(1), '0));
    // Fill all sixteen entries; the last one arrives as a new key through insert-or-update.
    offer(make_request(OP_INSERT, '0, '0, '0));
    offer(make_request(OP_INSERT, '1, '1, '1));
    for (int i = 1; i < 14; i++)
      offer(make_request(OP_INSERT, KEY_W'(i) * 32'h1111_1111, pick_value(), RANK_W'(i)));
    offer(make_request(OP_UPSERT, 32'hEEEE_EEEE, pick_value(), '0));
    offer(make_request(OP_INSERT, 32'h2222_2222, pick_value(), '0));
    offer(make_request(OP_INSERT, 32'h1234_5678, pick_value(), '0));
    offer(make_request(OP_UPSERT, 32'h8765_4321, pick_value(), '0));
    offer(make_request(OP_LOOKUP, '1, '0, '0));
    offer(make_request(OP_RANK, '0, '0, '1));
    offer(make_request(OP_ERASE, '0, '0, '0));
    offer(make_request(OP_RSVD6, 32'h3333_3333, '1, '1));
    offer(make_request(OP_RSVD7, 32'h4444_4444, '1, '1));
    wait_until_drained();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      phase = phase_e'((n / 50) % 3);
      if (n == 150 || n == 450) long_stall_tog <= ~long_stall_tog;
      if (n == 300 || $urandom_range(0, 99) == 0) wait_until_drained();
      offer(make_request(pick_op(phase), pick_key(), pick_value(),
                         RANK_W'($urandom_range(0, NUM_ENTRIES - 1))));
    end

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
